### rtl/core/msep_pkg.sv
// ----------------------------------------------------------------------------
// Sequence event parser package
// Shared types, command codes and tables for the track event parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msep_pkg;

	typedef enum logic [3:0] {
		PH_CMD    = 4'd0,
		PH_NDELTA = 4'd1,
		PH_NDUR   = 4'd2,
		PH_NVEL   = 4'd3,
		PH_SKIP   = 4'd4,
		PH_REST   = 4'd5,
		PH_HDELTA = 4'd6,
		PH_HDUR   = 4'd7,
		PH_PROG   = 4'd8,
		PH_TEMPO  = 4'd9,
		PH_VOL    = 4'd10,
		PH_LOOP   = 4'd11,
		PH_JUMP   = 4'd12
	} phase_t;

	typedef enum logic [3:0] {
		EV_NOTE    = 4'd0,
		EV_REST    = 4'd1,
		EV_HOLD    = 4'd2,
		EV_PROG    = 4'd3,
		EV_TEMPO   = 4'd4,
		EV_UNKNOWN = 4'd5,
		EV_LOOP    = 4'd6,
		EV_JUMP    = 4'd7,
		EV_RETURN  = 4'd8,
		EV_END     = 4'd9
	} event_kind_t;

	localparam logic [7:0] CMD_RETURN     = 8'hFF;
	localparam logic [7:0] CMD_NOP_A      = 8'h60;
	localparam logic [7:0] CMD_NOP_B      = 8'h61;
	localparam logic [7:0] CMD_SHORT_NOTE = 8'h62;
	localparam logic [7:0] CMD_SHORT_END  = 8'hC0;
	localparam logic [7:0] CMD_REST       = 8'hE0;
	localparam logic [7:0] CMD_HOLD       = 8'hE1;
	localparam logic [7:0] CMD_PROG       = 8'hE2;
	localparam logic [7:0] CMD_TEMPO      = 8'hEA;
	localparam logic [7:0] CMD_VOLUME     = 8'hEE;
	localparam logic [7:0] CMD_LOOP       = 8'hFD;
	localparam logic [7:0] CMD_JUMP       = 8'hFE;
	localparam logic [7:0] DUR_SHORT_FLAG = 8'h80;
	localparam logic [2:0] ADDR_FIELD_LEN = 3'd4;
	localparam logic [31:0] JUMP_RET_OFS  = 32'd5;
	localparam logic [12:0] RECIP_100     = 13'd5243;
	localparam int          RECIP_SHIFT   = 19;

	typedef struct packed {
		phase_t      phase;
		logic [6:0]  pending_note;
		logic [7:0]  pending_delta;
		logic [7:0]  pending_duration;
		logic [7:0]  last_delta;
		logic [7:0]  last_duration;
		logic [2:0]  skip_count;
		logic [31:0] field_acc;
		logic [31:0] event_begin;
		logic        inside_jump;
		logic [31:0] return_address;
		logic        track_ended;
		logic [2:0]  byte_count;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase:            PH_CMD,
		pending_note:     7'd0,
		pending_delta:    8'd0,
		pending_duration: 8'd0,
		last_delta:       8'd0,
		last_duration:    8'd0,
		skip_count:       3'd0,
		field_acc:        32'd0,
		event_begin:      32'd0,
		inside_jump:      1'b0,
		return_address:   32'd0,
		track_ended:      1'b0,
		byte_count:       3'd0
	};

	typedef struct packed {
		event_kind_t kind;
		logic [6:0]  note;
		logic [7:0]  velocity;
		logic [15:0] product;
		logic [7:0]  advance;
		logic [31:0] value;
		logic        redirect;
		logic [31:0] address;
		logic [2:0]  length;
	} event_t;

	typedef struct packed {
		logic       known;
		logic [2:0] extra;
	} skip_info_t;

	function automatic skip_info_t skip_lookup(input logic [7:0] code);
		skip_info_t r;
		r = '{known: 1'b1, extra: 3'd0};
		case (code)
			8'hC0, 8'hDE, 8'hE3, 8'hEC, 8'hF0, 8'hF2, 8'hFA: r.extra = 3'd1;
			8'hCE, 8'hD1, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hEF, 8'hF8: r.extra = 3'd2;
			8'hD0, 8'hE4, 8'hE5, 8'hE7, 8'hE9, 8'hF1, 8'hF3: r.extra = 3'd3;
			8'hE6, 8'hE8, 8'hF6, 8'hF7: r.extra = 3'd0;
			default: r.known = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/msep_if.sv
// ----------------------------------------------------------------------------
// Sequence event parser channels
// Valid/ready channels for track bytes in and decoded events out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface msep_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [31:0] byte_address;
	logic        track_start;

	modport source (output valid, data_byte, byte_address, track_start, input ready);
	modport sink (input valid, data_byte, byte_address, track_start, output ready);
endinterface

interface msep_event_if;
	logic        valid;
	logic        ready;
	logic [3:0]  event_kind;
	logic [6:0]  note_number;
	logic [7:0]  velocity;
	logic [9:0]  note_length;
	logic [7:0]  time_advance;
	logic [31:0] event_value;
	logic        fetch_redirect;
	logic [31:0] event_address;
	logic [2:0]  event_length;

	modport source (output valid, event_kind, note_number, velocity, note_length,
		time_advance, event_value, fetch_redirect, event_address, event_length,
		input ready);
	modport sink (input valid, event_kind, note_number, velocity, note_length,
		time_advance, event_value, fetch_redirect, event_address, event_length,
		output ready);
endinterface

`default_nettype wire

### rtl/core/msep_decode.sv
// ----------------------------------------------------------------------------
// Sequence event parser byte decoder
// Next parse state and completed event for one track byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msep_decode (
	input  msep_pkg::parse_state_t state,
	input  logic [7:0]             data_byte,
	input  logic [31:0]            byte_address,
	input  logic                   track_start,
	output msep_pkg::parse_state_t next_state,
	output logic                   emit,
	output msep_pkg::event_t       ev
);

	msep_pkg::parse_state_t st;
	msep_pkg::parse_state_t ns;
	msep_pkg::skip_info_t   sk;
	msep_pkg::event_t       e;
	logic                   fire;
	logic [7:0]             mul_a;
	logic [7:0]             mul_b;

	assign sk = msep_pkg::skip_lookup(data_byte);

	always_comb begin
		st    = track_start ? msep_pkg::STATE_RESET : state;
		ns    = st;
		fire  = 1'b0;
		e     = '0;
		mul_a = 8'd0;
		mul_b = 8'd0;
		if (!st.track_ended) begin
			if (st.phase == msep_pkg::PH_CMD) begin
				ns.event_begin = byte_address;
				ns.byte_count  = 3'd1;
				ns.field_acc   = 32'd0;
				if (data_byte == msep_pkg::CMD_RETURN) begin
					fire = 1'b1;
					if (st.inside_jump) begin
						ns.inside_jump = 1'b0;
						e.kind         = msep_pkg::EV_RETURN;
						e.value        = st.return_address;
						e.redirect     = 1'b1;
					end else begin
						ns.track_ended = 1'b1;
						e.kind         = msep_pkg::EV_END;
					end
				end else if (data_byte == msep_pkg::CMD_NOP_A ||
						data_byte == msep_pkg::CMD_NOP_B) begin
					ns.phase = msep_pkg::PH_CMD;
				end else if (data_byte < msep_pkg::CMD_SHORT_NOTE) begin
					ns.pending_note = data_byte[6:0];
					ns.phase        = msep_pkg::PH_NDELTA;
				end else if (data_byte < msep_pkg::CMD_SHORT_END) begin
					ns.pending_note  = 7'(data_byte - msep_pkg::CMD_SHORT_NOTE);
					ns.pending_delta = st.last_delta;
					ns.phase         = msep_pkg::PH_NDUR;
				end else if (data_byte == msep_pkg::CMD_REST) begin
					ns.phase = msep_pkg::PH_REST;
				end else if (data_byte == msep_pkg::CMD_HOLD) begin
					ns.phase = msep_pkg::PH_HDELTA;
				end else if (data_byte == msep_pkg::CMD_PROG) begin
					ns.phase = msep_pkg::PH_PROG;
				end else if (data_byte == msep_pkg::CMD_TEMPO) begin
					ns.phase = msep_pkg::PH_TEMPO;
				end else if (data_byte == msep_pkg::CMD_VOLUME) begin
					ns.phase = msep_pkg::PH_VOL;
				end else if (data_byte == msep_pkg::CMD_LOOP) begin
					ns.skip_count = msep_pkg::ADDR_FIELD_LEN;
					ns.phase      = msep_pkg::PH_LOOP;
				end else if (data_byte == msep_pkg::CMD_JUMP) begin
					ns.skip_count     = msep_pkg::ADDR_FIELD_LEN;
					ns.return_address = byte_address + msep_pkg::JUMP_RET_OFS;
					ns.phase          = msep_pkg::PH_JUMP;
				end else if (!sk.known) begin
					fire           = 1'b1;
					ns.track_ended = 1'b1;
					e.kind         = msep_pkg::EV_END;
				end else if (sk.extra == 3'd0) begin
					fire   = 1'b1;
					e.kind = msep_pkg::EV_UNKNOWN;
				end else begin
					ns.skip_count = sk.extra;
					ns.phase      = msep_pkg::PH_SKIP;
				end
			end else begin
				ns.byte_count = st.byte_count + 3'd1;
				case (st.phase)
					msep_pkg::PH_NDELTA: begin
						ns.pending_delta = data_byte;
						ns.last_delta    = data_byte;
						ns.phase         = msep_pkg::PH_NDUR;
					end
					msep_pkg::PH_NDUR: begin
						if (data_byte < msep_pkg::DUR_SHORT_FLAG) begin
							ns.pending_duration = data_byte;
							ns.last_duration    = data_byte;
							ns.phase            = msep_pkg::PH_NVEL;
						end else begin
							ns.pending_duration = st.last_duration;
							fire       = 1'b1;
							e.kind     = msep_pkg::EV_NOTE;
							e.note     = st.pending_note;
							e.velocity = data_byte - msep_pkg::DUR_SHORT_FLAG;
							e.advance  = st.pending_delta;
							mul_a      = st.pending_delta;
							mul_b      = st.last_duration;
						end
					end
					msep_pkg::PH_NVEL: begin
						fire       = 1'b1;
						e.kind     = msep_pkg::EV_NOTE;
						e.note     = st.pending_note;
						e.velocity = data_byte;
						e.advance  = st.pending_delta;
						mul_a      = st.pending_delta;
						mul_b      = st.pending_duration;
					end
					msep_pkg::PH_SKIP: begin
						ns.skip_count = (st.skip_count != 3'd0) ?
							st.skip_count - 3'd1 : st.skip_count;
						if (ns.skip_count == 3'd0) begin
							fire   = 1'b1;
							e.kind = msep_pkg::EV_UNKNOWN;
						end
					end
					msep_pkg::PH_REST: begin
						fire      = 1'b1;
						e.kind    = msep_pkg::EV_REST;
						e.advance = data_byte;
					end
					msep_pkg::PH_HDELTA: begin
						ns.pending_delta = data_byte;
						ns.phase         = msep_pkg::PH_HDUR;
					end
					msep_pkg::PH_HDUR: begin
						fire      = 1'b1;
						e.kind    = msep_pkg::EV_HOLD;
						e.advance = st.pending_delta;
						mul_a     = st.pending_delta;
						mul_b     = data_byte;
					end
					msep_pkg::PH_PROG: begin
						fire    = 1'b1;
						e.kind  = msep_pkg::EV_PROG;
						e.value = {24'd0, data_byte};
					end
					msep_pkg::PH_TEMPO: begin
						fire    = 1'b1;
						e.kind  = msep_pkg::EV_TEMPO;
						e.value = {24'd0, data_byte};
					end
					msep_pkg::PH_VOL: begin
						ns.phase = msep_pkg::PH_CMD;
					end
					msep_pkg::PH_LOOP, msep_pkg::PH_JUMP: begin
						ns.field_acc  = {st.field_acc[23:0], data_byte};
						ns.skip_count = (st.skip_count != 3'd0) ?
							st.skip_count - 3'd1 : st.skip_count;
						if (ns.skip_count == 3'd0) begin
							fire = 1'b1;
							if (st.phase == msep_pkg::PH_LOOP) begin
								e.kind = msep_pkg::EV_LOOP;
							end else begin
								ns.inside_jump = 1'b1;
								e.kind         = msep_pkg::EV_JUMP;
								e.value        = ns.field_acc;
								e.redirect     = 1'b1;
							end
						end
					end
					default: begin
						ns.phase = msep_pkg::PH_CMD;
					end
				endcase
			end
			if (fire) begin
				ns.phase = msep_pkg::PH_CMD;
			end
		end
		e.product = 16'(mul_a) * 16'(mul_b);
		e.address = ns.event_begin;
		e.length  = ns.byte_count;
	end

	assign next_state = ns;
	assign emit       = fire;
	assign ev         = e;

endmodule

`default_nettype wire

### rtl/core/msep_scale.sv
// ----------------------------------------------------------------------------
// Sequence event parser length scaler
// Divides delta*dur by 100 and applies the note and hold length limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msep_scale (
	input  msep_pkg::event_kind_t kind,
	input  logic [15:0]           product,
	input  logic [7:0]            delta,
	output logic [9:0]            note_length
);

	logic [28:0] scaled;
	logic [9:0]  quot;

	// The reciprocal is exact for products up to 43690; a larger product of two bytes can give a quotient one too high.
	assign scaled = 29'(product) * 29'(msep_pkg::RECIP_100);
	assign quot   = scaled[msep_pkg::RECIP_SHIFT +: 10];

	always_comb begin
		case (kind)
			msep_pkg::EV_NOTE: note_length = (quot == 10'd0) ? 10'd1 : quot;
			msep_pkg::EV_HOLD: note_length = (quot > {2'b00, delta}) ? {2'b00, delta} : quot;
			default:           note_length = 10'd0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/music_sequence_event_parser.sv
// ----------------------------------------------------------------------------
// Music sequence track event parser
// Decodes a track byte stream into note, rest, hold, control and flow events.
// ----------------------------------------------------------------------------
// Track bytes enter on byte_in, one beat per byte with its address; a beat
// with track_start set clears all parse state before the byte is decoded.
// Decoded events leave on event_out, one beat per event, issued on the byte
// that completes the event. Jump and return events raise fetch_redirect and
// the byte source should continue at event_value.
// The block is a three-register pipeline: an input register, a decode stage
// that updates the parse state and forms delta*dur, and a result register
// where the length is divided by 100. An event is valid on event_out once
// its last byte has passed the input, decode and result registers. One byte
// is taken in every cycle while event_out is not stalled.
// When event_out stalls, the whole pipeline holds and byte_in.ready falls
// once the input register is full; no beat is lost or repeated.
// Reset clears the valid bits and returns the parser to expecting a command
// byte with all parse state at zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module music_sequence_event_parser (
	input  wire logic     clk,
	input  wire logic     arst_n,
	msep_byte_if.sink     byte_in,
	msep_event_if.source  event_out
);

	logic                   advance;
	logic                   valid_s1;
	logic [7:0]             data_byte_s1;
	logic [31:0]            byte_address_s1;
	logic                   track_start_s1;
	msep_pkg::parse_state_t state_q;
	msep_pkg::parse_state_t state_next;
	logic                   dec_emit;
	msep_pkg::event_t       dec_ev;
	logic                   valid_s2;
	msep_pkg::event_t       ev_s2;
	logic [9:0]             scaled_len;
	logic                   out_valid_q;
	msep_pkg::event_t       ev_q;
	logic [9:0]             note_length_q;

	assign advance       = !out_valid_q || event_out.ready;
	assign byte_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			data_byte_s1    <= byte_in.data_byte;
			byte_address_s1 <= byte_in.byte_address;
			track_start_s1  <= byte_in.track_start;
		end
	end

	msep_decode u_decode (
		.state        (state_q),
		.data_byte    (data_byte_s1),
		.byte_address (byte_address_s1),
		.track_start  (track_start_s1),
		.next_state   (state_next),
		.emit         (dec_emit),
		.ev           (dec_ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= msep_pkg::STATE_RESET;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && dec_emit;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && dec_emit) begin
			ev_s2 <= dec_ev;
		end
	end

	msep_scale u_scale (
		.kind        (ev_s2.kind),
		.product     (ev_s2.product),
		.delta       (ev_s2.advance),
		.note_length (scaled_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			ev_q          <= ev_s2;
			note_length_q <= scaled_len;
		end
	end

	assign event_out.valid          = out_valid_q;
	assign event_out.event_kind     = ev_q.kind;
	assign event_out.note_number    = ev_q.note;
	assign event_out.velocity       = ev_q.velocity;
	assign event_out.note_length    = note_length_q;
	assign event_out.time_advance   = ev_q.advance;
	assign event_out.event_value    = ev_q.value;
	assign event_out.fetch_redirect = ev_q.redirect;
	assign event_out.event_address  = ev_q.address;
	assign event_out.event_length   = ev_q.length;

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the music sequence track event parser
// Feeds directed and random track byte streams through the byte channel in
// bursts, stalls the event channel, and checks every decoded event against
// a cycle-free predictor of the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import msep_pkg::*;

	localparam int TRACK_BYTES = 1350;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		event_kind_t kind;
		logic [6:0]  note;
		logic [7:0]  vel;
		logic [9:0]  len;
		logic [7:0]  adv;
		logic [31:0] value;
		logic        redirect;
		logic [31:0] addr;
		logic [2:0]  nbytes;
	} track_event_t;

	typedef struct {
		logic [7:0]  data;
		logic [31:0] addr;
		logic        first;
		bit          drain;
	} track_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	msep_byte_if  byte_in();
	msep_event_if event_out();

	music_sequence_event_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_in),
		.event_out (event_out)
	);

	always #4 clk = ~clk;

	// Parser state as the predictor sees it.
	phase_t      trk_phase;
	logic [6:0]  note_held;
	logic [7:0]  delta_held;
	logic [7:0]  dur_held;
	logic [7:0]  prev_delta;
	logic [7:0]  prev_dur;
	int          bytes_to_skip;
	logic [31:0] addr_accum;
	logic [31:0] ev_start_addr;
	logic        in_subroutine;
	logic [31:0] resume_addr;
	logic        trk_done;
	logic [2:0]  ev_bytes;

	track_event_t expected_events[$];
	track_beat_t  track_bytes_to_send[$];

	// Stream generator state.
	logic [31:0] stream_addr;
	bit          start_next;
	bit          drain_next;
	bit          force_start;
	bit          gen_in_jump;
	bit          gen_ended;
	logic [31:0] gen_ret;
	int          items_queued;
	int          ignored_queued;
	int          commands_queued;
	logic [7:0]  known_skip_codes[$];
	logic [7:0]  undefined_codes[$];

	// Handshake bookkeeping.
	bit           in_fire;
	bit           offering;
	track_beat_t  cur_beat;
	int           burst_left;
	int           gap_left;
	int           bytes_taken;
	int unsigned  rx_cycle;
	int           hold_left;
	bit           hold_done;
	bit           ready_next;
	int           quiet_cycles;
	int           mismatches;
	track_event_t predicted;
	track_event_t seen;
	track_event_t want;

	function automatic int skip_extra(input logic [7:0] c);
		case (c)
			8'hC0, 8'hDE, 8'hE3, 8'hEC, 8'hF0, 8'hF2, 8'hFA: return 1;
			8'hCE, 8'hD1, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hEF, 8'hF8: return 2;
			8'hD0, 8'hE4, 8'hE5, 8'hE7, 8'hE9, 8'hF1, 8'hF3: return 3;
			8'hE6, 8'hE8, 8'hF6, 8'hF7: return 0;
			default: return -1;
		endcase
	endfunction

	function automatic void clear_parser();
		trk_phase = PH_CMD;
		note_held = '0;
		delta_held = '0;
		dur_held = '0;
		prev_delta = '0;
		prev_dur = '0;
		bytes_to_skip = 0;
		addr_accum = '0;
		ev_start_addr = '0;
		in_subroutine = 1'b0;
		resume_addr = '0;
		trk_done = 1'b0;
		ev_bytes = '0;
	endfunction

	function automatic track_event_t finish_event(input event_kind_t kind,
		input logic [6:0] note, input logic [7:0] vel, input logic [9:0] len,
		input logic [7:0] adv, input logic [31:0] value, input logic redirect);
		track_event_t ev;
		ev.kind = kind;
		ev.note = note;
		ev.vel = vel;
		ev.len = len;
		ev.adv = adv;
		ev.value = value;
		ev.redirect = redirect;
		ev.addr = ev_start_addr;
		ev.nbytes = ev_bytes;
		trk_phase = PH_CMD;
		return ev;
	endfunction

	function automatic logic [9:0] note_ticks(input logic [7:0] delta, input logic [7:0] dur);
		int prod;
		prod = (int'(delta) * int'(dur)) / 100;
		return (prod == 0) ? 10'd1 : 10'(prod);
	endfunction

	function automatic bit decode_track_byte(input logic [7:0] b, input logic [31:0] a,
		input logic first, output track_event_t ev);
		int  extra;
		int  held;
		bit  got;
		ev = '0;
		got = 1'b0;
		if (first)
			clear_parser();
		if (trk_done)
			return 1'b0;
		if (trk_phase == PH_CMD) begin
			ev_start_addr = a;
			ev_bytes = 3'd1;
			addr_accum = '0;
			if (b == CMD_RETURN) begin
				got = 1'b1;
				if (in_subroutine) begin
					in_subroutine = 1'b0;
					ev = finish_event(EV_RETURN, 0, 0, 0, 0, resume_addr, 1'b1);
				end else begin
					trk_done = 1'b1;
					ev = finish_event(EV_END, 0, 0, 0, 0, 0, 1'b0);
				end
			end else if (b == CMD_NOP_A || b == CMD_NOP_B) begin
				got = 1'b0;
			end else if (b < CMD_SHORT_NOTE) begin
				note_held = b[6:0];
				trk_phase = PH_NDELTA;
			end else if (b < CMD_SHORT_END) begin
				note_held = 7'(b - CMD_SHORT_NOTE);
				delta_held = prev_delta;
				trk_phase = PH_NDUR;
			end else begin
				case (b)
					CMD_REST: trk_phase = PH_REST;
					CMD_HOLD: trk_phase = PH_HDELTA;
					CMD_PROG: trk_phase = PH_PROG;
					CMD_TEMPO: trk_phase = PH_TEMPO;
					CMD_VOLUME: trk_phase = PH_VOL;
					CMD_LOOP: begin
						bytes_to_skip = ADDR_FIELD_LEN;
						trk_phase = PH_LOOP;
					end
					CMD_JUMP: begin
						bytes_to_skip = ADDR_FIELD_LEN;
						resume_addr = a + JUMP_RET_OFS;
						trk_phase = PH_JUMP;
					end
					default: begin
						extra = skip_extra(b);
						if (extra < 0) begin
							trk_done = 1'b1;
							got = 1'b1;
							ev = finish_event(EV_END, 0, 0, 0, 0, 0, 1'b0);
						end else if (extra == 0) begin
							got = 1'b1;
							ev = finish_event(EV_UNKNOWN, 0, 0, 0, 0, 0, 1'b0);
						end else begin
							bytes_to_skip = extra;
							trk_phase = PH_SKIP;
						end
					end
				endcase
			end
			return got;
		end
		ev_bytes = ev_bytes + 3'd1;
		case (trk_phase)
			PH_NDELTA: begin
				delta_held = b;
				prev_delta = b;
				trk_phase = PH_NDUR;
			end
			PH_NDUR: begin
				if (b < DUR_SHORT_FLAG) begin
					dur_held = b;
					prev_dur = b;
					trk_phase = PH_NVEL;
				end else begin
					dur_held = prev_dur;
					got = 1'b1;
					ev = finish_event(EV_NOTE, note_held, b - DUR_SHORT_FLAG,
						note_ticks(delta_held, dur_held), delta_held, 0, 1'b0);
				end
			end
			PH_NVEL: begin
				got = 1'b1;
				ev = finish_event(EV_NOTE, note_held, b, note_ticks(delta_held, dur_held),
					delta_held, 0, 1'b0);
			end
			PH_SKIP: begin
				if (bytes_to_skip > 0)
					bytes_to_skip--;
				if (bytes_to_skip == 0) begin
					got = 1'b1;
					ev = finish_event(EV_UNKNOWN, 0, 0, 0, 0, 0, 1'b0);
				end
			end
			PH_REST: begin
				got = 1'b1;
				ev = finish_event(EV_REST, 0, 0, 0, b, 0, 1'b0);
			end
			PH_HDELTA: begin
				delta_held = b;
				trk_phase = PH_HDUR;
			end
			PH_HDUR: begin
				held = (int'(delta_held) * int'(b)) / 100;
				if (held > int'(delta_held))
					held = int'(delta_held);
				got = 1'b1;
				ev = finish_event(EV_HOLD, 0, 0, 10'(held), delta_held, 0, 1'b0);
			end
			PH_PROG: begin
				got = 1'b1;
				ev = finish_event(EV_PROG, 0, 0, 0, 0, {24'd0, b}, 1'b0);
			end
			PH_TEMPO: begin
				got = 1'b1;
				ev = finish_event(EV_TEMPO, 0, 0, 0, 0, {24'd0, b}, 1'b0);
			end
			PH_VOL: trk_phase = PH_CMD;
			PH_LOOP, PH_JUMP: begin
				addr_accum = {addr_accum[23:0], b};
				if (bytes_to_skip > 0)
					bytes_to_skip--;
				if (bytes_to_skip == 0) begin
					got = 1'b1;
					if (trk_phase == PH_LOOP) begin
						ev = finish_event(EV_LOOP, 0, 0, 0, 0, 0, 1'b0);
					end else begin
						in_subroutine = 1'b1;
						ev = finish_event(EV_JUMP, 0, 0, 0, 0, addr_accum, 1'b1);
					end
				end
			end
			default: trk_phase = PH_CMD;
		endcase
		return got;
	endfunction

	function automatic string event_text(input track_event_t e);
		return $sformatf("kind=%0d note=%0d vel=%0d len=%0d adv=%0d value=%h redirect=%0b addr=%h bytes=%0d",
			e.kind, e.note, e.vel, e.len, e.adv, e.value, e.redirect, e.addr, e.nbytes);
	endfunction

	task automatic report_error(input string msg);
		if (mismatches < 10)
			$display("tb: %s", msg);
		mismatches++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		track_beat_t beat;
		beat = '{data: b, addr: stream_addr, first: start_next, drain: drain_next};
		track_bytes_to_send.insert(track_bytes_to_send.size(), beat);
		start_next = 1'b0;
		drain_next = 1'b0;
		stream_addr++;
		items_queued++;
	endtask

	task automatic queue_duration_bytes();
		if ($urandom_range(0, 3) == 0) begin
			push_byte(8'($urandom_range(8'h80, 8'hFF)));
		end else begin
			push_byte(8'($urandom_range(0, 8'h7F)));
			push_byte(8'($urandom));
		end
	endtask

	task automatic queue_random_command();
		int          pick;
		logic [7:0]  code;
		logic [31:0] target;
		logic [31:0] jump_at;
		start_next = force_start || ($urandom_range(0, 49) == 0);
		drain_next = (commands_queued % 97) == 50;
		force_start = 1'b0;
		commands_queued++;
		if (start_next) begin
			gen_in_jump = 1'b0;
			if ($urandom_range(0, 1) == 1)
				stream_addr = $urandom;
		end
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			push_byte(8'($urandom_range(0, 8'h5F)));
			push_byte(8'($urandom));
			queue_duration_bytes();
		end else if (pick < 48) begin
			push_byte(8'($urandom_range(CMD_SHORT_NOTE, CMD_SHORT_END - 8'd1)));
			queue_duration_bytes();
		end else if (pick < 52) begin
			push_byte(($urandom_range(0, 1) == 1) ? CMD_NOP_A : CMD_NOP_B);
		end else if (pick < 59) begin
			push_byte(CMD_REST);
			push_byte(8'($urandom));
		end else if (pick < 66) begin
			push_byte(CMD_HOLD);
			push_byte(8'($urandom));
			push_byte(8'($urandom));
		end else if (pick < 71) begin
			push_byte(CMD_PROG);
			push_byte(8'($urandom));
		end else if (pick < 76) begin
			push_byte(CMD_TEMPO);
			push_byte(8'($urandom));
		end else if (pick < 80) begin
			push_byte(CMD_VOLUME);
			push_byte(8'($urandom));
		end else if (pick < 84) begin
			push_byte(CMD_LOOP);
			repeat (ADDR_FIELD_LEN) push_byte(8'($urandom));
		end else if (pick < 90) begin
			target = $urandom;
			jump_at = stream_addr;
			push_byte(CMD_JUMP);
			push_byte(target[31:24]);
			push_byte(target[23:16]);
			push_byte(target[15:8]);
			push_byte(target[7:0]);
			gen_ret = jump_at + JUMP_RET_OFS;
			gen_in_jump = 1'b1;
			stream_addr = target;
		end else if (pick < 95) begin
			push_byte(CMD_RETURN);
			if (gen_in_jump) begin
				gen_in_jump = 1'b0;
				stream_addr = gen_ret;
			end else begin
				gen_ended = 1'b1;
			end
		end else if (pick < 98) begin
			code = known_skip_codes[$urandom_range(0, known_skip_codes.size() - 1)];
			push_byte(code);
			repeat (skip_extra(code)) push_byte(8'($urandom));
		end else if (pick < 99) begin
			push_byte(undefined_codes[$urandom_range(0, undefined_codes.size() - 1)]);
			gen_ended = 1'b1;
		end else begin
			start_next = start_next || ($urandom_range(0, 2) == 0);
			push_byte(8'($urandom));
		end
	endtask

	initial begin
		int         c;
		logic [7:0] code;
		arst_n = 1'b0;
		byte_in.valid = 1'b0;
		byte_in.data_byte = '0;
		byte_in.byte_address = '0;
		byte_in.track_start = 1'b0;
		event_out.ready = 1'b0;
		clear_parser();
		mismatches = 0;

		for (c = 8'hC0; c <= 8'hFF; c++) begin
			code = c[7:0];
			if (code inside {CMD_REST, CMD_HOLD, CMD_PROG, CMD_TEMPO, CMD_VOLUME,
				CMD_LOOP, CMD_JUMP, CMD_RETURN})
				continue;
			if (skip_extra(code) >= 0)
				known_skip_codes.insert(known_skip_codes.size(), code);
			else
				undefined_codes.insert(undefined_codes.size(), code);
		end

		// Directed part: zero delta gives a length of one, the widest note,
		// a short note with the last delta, a clamped hold, a jump whose
		// return address wraps, a nested jump, return, end, and an ignored byte.
		stream_addr = 32'hFFFF_FFFD;
		start_next = 1'b1;
		push_byte(8'h5F);
		push_byte(8'h00);
		push_byte(8'h80);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h7F);
		push_byte(8'hFF);
		push_byte(8'hBF);
		push_byte(8'hFF);
		push_byte(CMD_HOLD);
		push_byte(8'hC8);
		push_byte(8'hFF);
		stream_addr = 32'hFFFF_FFFC;
		push_byte(CMD_JUMP);
		repeat (ADDR_FIELD_LEN) push_byte(8'hFF);
		stream_addr = 32'hFFFF_FFFF;
		push_byte(CMD_JUMP);
		repeat (ADDR_FIELD_LEN) push_byte(8'h00);
		push_byte(CMD_RETURN);
		push_byte(CMD_RETURN);
		push_byte(8'h12);
		ignored_queued++;
		start_next = 1'b1;
		push_byte(8'hE6);
		push_byte(8'hC1);
		gen_ended = 1'b1;

		while (items_queued - ignored_queued < TRACK_BYTES) begin
			if (gen_ended) begin
				repeat ($urandom_range(0, 3)) begin
					push_byte(8'($urandom));
					ignored_queued++;
				end
				force_start = 1'b1;
				gen_ended = 1'b0;
			end
			queue_random_command();
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (track_bytes_to_send.size() != 0 || offering)
			@(posedge clk);
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		while (expected_events.size() != 0)
			report_error($sformatf("missing event %s", event_text(expected_events.pop_front())));
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// A beat accepted at the last rising edge is retired here; a beat marked
	// for draining waits until every predicted event has been seen.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire)
				offering = 1'b0;
			if (!offering) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (track_bytes_to_send.size() != 0 &&
					!(track_bytes_to_send[0].drain && expected_events.size() != 0)) begin
					cur_beat = track_bytes_to_send.pop_front();
					offering = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
							: $urandom_range(0, 12);
						gap_left = $urandom_range(1, 6);
					end
				end
			end
			byte_in.valid <= offering;
			if (offering) begin
				byte_in.data_byte <= cur_beat.data;
				byte_in.byte_address <= cur_beat.addr;
				byte_in.track_start <= cur_beat.first;
			end
		end
	end

	always @(negedge clk) begin
		rx_cycle++;
		if (!hold_done && bytes_taken >= 500) begin
			hold_left = 150;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			ready_next = 1'b0;
		end else begin
			case ((rx_cycle / 200) % 4)
				0: ready_next = 1'b1;
				1: ready_next = $urandom_range(0, 3) != 0;
				2: ready_next = $urandom_range(0, 3) == 0;
				default: ready_next = rx_cycle[2];
			endcase
		end
		event_out.ready <= ready_next;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_fire = byte_in.valid && byte_in.ready;
			if (in_fire) begin
				bytes_taken++;
				if (decode_track_byte(byte_in.data_byte, byte_in.byte_address,
					byte_in.track_start, predicted))
					expected_events.insert(expected_events.size(), predicted);
			end
			if (event_out.valid && event_out.ready) begin
				seen.kind = event_kind_t'(event_out.event_kind);
				seen.note = event_out.note_number;
				seen.vel = event_out.velocity;
				seen.len = event_out.note_length;
				seen.adv = event_out.time_advance;
				seen.value = event_out.event_value;
				seen.redirect = event_out.fetch_redirect;
				seen.addr = event_out.event_address;
				seen.nbytes = event_out.event_length;
				if (expected_events.size() == 0) begin
					report_error($sformatf("unexpected event %s", event_text(seen)));
				end else begin
					want = expected_events.pop_front();
					if (seen !== want)
						report_error($sformatf("event mismatch: expected %s, got %s",
							event_text(want), event_text(seen)));
				end
			end
		end else begin
			in_fire = 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_in.valid && byte_in.ready) || (event_out.valid && event_out.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

endmodule
